// File: rtl/core/vfc_pkg.sv
// Shared types, widths and constants for the vehicle footprint corner block.
`timescale 1ns / 1ps
`default_nettype none
package vfc_pkg;

    localparam int REG_W      = 16;
    localparam int HEADING_W  = 16;
    localparam int ANGLE_W    = 24;
    localparam int CORDIC_W   = 32;
    localparam int DU_W       = REG_W + 2;
    localparam int PROD_W     = DU_W + CORDIC_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 31;
    localparam int RND_W      = SUM_W - FRAC_SHIFT;
    localparam int ATAN_LEN   = 24;

    localparam logic [REG_W-1:0] BODY_LENGTH_RST   = 16'd3072;
    localparam logic [REG_W-1:0] BODY_WIDTH_RST    = 16'd512;
    localparam logic [REG_W-1:0] REAR_OVERHANG_RST = 16'd256;

    // 1/K in Q2.30
    localparam logic signed [CORDIC_W-1:0] INV_GAIN = 32'sd652032874;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC_SHIFT - 1));

    // atan(2^-i) in turns / 2^24
    localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050,
        24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
        24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
        24'sd652,     24'sd326,     24'sd163,    24'sd81,
        24'sd41,      24'sd20,      24'sd10,     24'sd5,
        24'sd3,       24'sd1,       24'sd1,      24'sd0
    };

    typedef enum logic [1:0] {
        REG_BODY_LENGTH   = 2'd0,
        REG_BODY_WIDTH    = 2'd1,
        REG_REAR_OVERHANG = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef enum logic [1:0] {
        CORNER_FL = 2'd0,
        CORNER_FR = 2'd1,
        CORNER_RR = 2'd2,
        CORNER_RL = 2'd3
    } corner_t;

    typedef struct packed {
        logic  valid;
        quad_t quad;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/vfc_if.sv
// Valid/ready channel interfaces for poses in and corners out.
`timescale 1ns / 1ps
`default_nettype none
interface vfc_pose_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pose_x;
    logic signed [COORD_BITS-1:0] pose_y;
    logic        [15:0]           heading;

    modport source (output valid, pose_x, pose_y, heading, input ready);
    modport sink   (input valid, pose_x, pose_y, heading, output ready);
endinterface

interface vfc_corner_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic        [1:0]            corner_index;
    logic signed [COORD_BITS-1:0] corner_x;
    logic signed [COORD_BITS-1:0] corner_y;
    logic                         last_corner;

    modport source (output valid, corner_index, corner_x, corner_y, last_corner, input ready);
    modport sink   (input valid, corner_index, corner_x, corner_y, last_corner, output ready);
endinterface
`default_nettype wire

// File: rtl/core/vfc_cordic_cell.sv
// One rotation-mode CORDIC stage with its pose payload register.
`timescale 1ns / 1ps
`default_nettype none
module vfc_cordic_cell #(
    parameter int STAGE      = 0,
    parameter int COORD_BITS = 24
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   adv,
    input  wire vfc_pkg::cell_ctrl_t              ctrl_in,
    input  wire logic signed [vfc_pkg::CORDIC_W-1:0] x_in,
    input  wire logic signed [vfc_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [vfc_pkg::ANGLE_W-1:0]  z_in,
    input  wire logic signed [COORD_BITS-1:0]     px_in,
    input  wire logic signed [COORD_BITS-1:0]     py_in,
    output vfc_pkg::cell_ctrl_t                   ctrl_out,
    output logic signed [vfc_pkg::CORDIC_W-1:0]   x_out,
    output logic signed [vfc_pkg::CORDIC_W-1:0]   y_out,
    output logic signed [vfc_pkg::ANGLE_W-1:0]    z_out,
    output logic signed [COORD_BITS-1:0]          px_out,
    output logic signed [COORD_BITS-1:0]          py_out
);
    import vfc_pkg::*;

    cell_ctrl_t                   ctrl_reg;
    logic signed [CORDIC_W-1:0]   x_reg, x_next;
    logic signed [CORDIC_W-1:0]   y_reg, y_next;
    logic signed [ANGLE_W-1:0]    z_reg, z_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [CORDIC_W-1:0]   xs, ys;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!z_in[ANGLE_W-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_TABLE[STAGE];
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            px_reg <= px_in;
            py_reg <= py_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign px_out   = px_reg;
    assign py_out   = py_reg;

endmodule
`default_nettype wire

// File: rtl/core/vfc_corner_unit.sv
// Corner sequencer: holds one pose's sin/cos and emits four rotated corners.
`timescale 1ns / 1ps
`default_nettype none
module vfc_corner_unit #(
    parameter int COORD_BITS = 24
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire vfc_pkg::cell_ctrl_t                 ctrl_in,
    input  wire logic signed [vfc_pkg::CORDIC_W-1:0] x_in,
    input  wire logic signed [vfc_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [COORD_BITS-1:0]        px_in,
    input  wire logic signed [COORD_BITS-1:0]        py_in,
    input  wire logic [vfc_pkg::REG_W-1:0]           body_length,
    input  wire logic [vfc_pkg::REG_W-1:0]           body_width,
    input  wire logic [vfc_pkg::REG_W-1:0]           rear_overhang,
    output logic                                     take,
    vfc_corner_if.source                             corners
);
    import vfc_pkg::*;

    localparam int SW = ((COORD_BITS > RND_W) ? COORD_BITS : RND_W) + 1;
    localparam logic signed [SW-1:0] SAT_MAX =
        SW'((longint'(1) <<< (COORD_BITS - 1)) - longint'(1));
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-(longint'(1) <<< (COORD_BITS - 1)));

    // body geometry, doubled so the half width stays integral
    logic signed [DU_W-1:0]   du_front_reg, du_rear_reg;
    logic signed [DU_W-1:0]   len_ext, ovh_ext;
    logic signed [REG_W:0]    w_reg;

    // pose hold
    logic                         hold_valid_reg, hold_valid_next;
    corner_t                      k_reg, k_next;
    logic signed [CORDIC_W-1:0]   c_reg, s_reg, c_next, s_next;
    logic signed [COORD_BITS-1:0] hpx_reg, hpy_reg;

    // product stage
    logic                         m_valid_reg;
    corner_t                      m_k_reg;
    logic signed [PROD_W-1:0]     p_uc_reg, p_us_reg, p_wc_reg, p_ws_reg;
    logic signed [PROD_W-1:0]     p_uc_next, p_us_next, p_wc_next, p_ws_next;
    logic signed [DU_W-1:0]       du_sel;
    logic signed [COORD_BITS-1:0] m_px_reg, m_py_reg;

    // sum stage
    logic                         a_valid_reg;
    corner_t                      a_k_reg;
    logic signed [RND_W-1:0]      rx_reg, ry_reg, rx_next, ry_next;
    logic signed [SUM_W-1:0]      sx, sy;
    logic signed [COORD_BITS-1:0] a_px_reg, a_py_reg;

    // output stage
    logic                         o_valid_reg;
    corner_t                      o_k_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic signed [SW-1:0]         tx, ty;

    logic adv_c;
    logic issue;
    logic last_issue;

    assign adv_c      = !o_valid_reg || corners.ready;
    assign issue      = hold_valid_reg && adv_c;
    assign last_issue = issue && (k_reg == CORNER_RL);
    assign take       = ctrl_in.valid && (!hold_valid_reg || last_issue);

    assign len_ext = {2'b00, body_length};
    assign ovh_ext = {2'b00, rear_overhang};

    always_ff @(posedge clk)
    begin
        du_front_reg <= (len_ext - ovh_ext) <<< 1;
        du_rear_reg  <= -(ovh_ext <<< 1);
        w_reg        <= {1'b0, body_width};
    end

    // quadrant fix-up
    always_comb
    begin
        unique case (ctrl_in.quad)
            QUAD_90:
            begin
                c_next = -y_in;
                s_next = x_in;
            end
            QUAD_180:
            begin
                c_next = -x_in;
                s_next = -y_in;
            end
            QUAD_270:
            begin
                c_next = y_in;
                s_next = -x_in;
            end
            default:
            begin
                c_next = x_in;
                s_next = y_in;
            end
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (last_issue)
        begin
            hold_valid_next = 1'b0;
        end
        k_next = issue ? corner_t'(k_reg + 2'd1) : k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            k_reg          <= CORNER_FL;
            m_valid_reg    <= 1'b0;
            a_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            k_reg          <= k_next;
            if (adv_c)
            begin
                m_valid_reg <= issue;
                a_valid_reg <= m_valid_reg;
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            hpx_reg <= px_in;
            hpy_reg <= py_in;
        end
    end

    // front corners use the front offset, rear corners the rear one
    always_comb
    begin
        du_sel    = ((k_reg == CORNER_FL) || (k_reg == CORNER_FR)) ? du_front_reg : du_rear_reg;
        p_uc_next = PROD_W'(du_sel) * PROD_W'(c_reg);
        p_us_next = PROD_W'(du_sel) * PROD_W'(s_reg);
        p_wc_next = PROD_W'(w_reg) * PROD_W'(c_reg);
        p_ws_next = PROD_W'(w_reg) * PROD_W'(s_reg);
    end

    // left corners take +width, right corners -width
    always_comb
    begin
        if ((m_k_reg == CORNER_FL) || (m_k_reg == CORNER_RL))
        begin
            sx = SUM_W'(p_uc_reg) - SUM_W'(p_ws_reg) + ROUND_HALF;
            sy = SUM_W'(p_us_reg) + SUM_W'(p_wc_reg) + ROUND_HALF;
        end
        else
        begin
            sx = SUM_W'(p_uc_reg) + SUM_W'(p_ws_reg) + ROUND_HALF;
            sy = SUM_W'(p_us_reg) - SUM_W'(p_wc_reg) + ROUND_HALF;
        end
        rx_next = sx[SUM_W-1:FRAC_SHIFT];
        ry_next = sy[SUM_W-1:FRAC_SHIFT];
    end

    always_comb
    begin
        tx = SW'(rx_reg) + SW'(a_px_reg);
        ty = SW'(ry_reg) + SW'(a_py_reg);
        if (tx > SAT_MAX)
        begin
            ox_next = SAT_MAX[COORD_BITS-1:0];
        end
        else if (tx < SAT_MIN)
        begin
            ox_next = SAT_MIN[COORD_BITS-1:0];
        end
        else
        begin
            ox_next = tx[COORD_BITS-1:0];
        end
        if (ty > SAT_MAX)
        begin
            oy_next = SAT_MAX[COORD_BITS-1:0];
        end
        else if (ty < SAT_MIN)
        begin
            oy_next = SAT_MIN[COORD_BITS-1:0];
        end
        else
        begin
            oy_next = ty[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            m_k_reg  <= k_reg;
            p_uc_reg <= p_uc_next;
            p_us_reg <= p_us_next;
            p_wc_reg <= p_wc_next;
            p_ws_reg <= p_ws_next;
            m_px_reg <= hpx_reg;
            m_py_reg <= hpy_reg;

            a_k_reg  <= m_k_reg;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            a_px_reg <= m_px_reg;
            a_py_reg <= m_py_reg;

            o_k_reg  <= a_k_reg;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
        end
    end

    assign corners.valid        = o_valid_reg;
    assign corners.corner_index = o_k_reg;
    assign corners.corner_x     = ox_reg;
    assign corners.corner_y     = oy_reg;
    assign corners.last_corner  = (o_k_reg == CORNER_RL);

endmodule
`default_nettype wire

// File: rtl/core/vehicle_footprint_corners_top.sv
// Vehicle footprint corners: CORDIC cell chain feeding a four-corner sequencer.
// A pose passes the CORDIC cells, then the hold, product, sum and output registers.
// After its first corner, the other three follow one per cycle when the sink is ready.
// Single shared multiply/add path: a pose loads when idle or as the last corner issues.
// The CORDIC chain stalls as a whole while the corner sequencer is still busy.
// Reset: all valid flags clear; registers return to length 3072, width 512, overhang 256.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_footprint_corners_top #(
    parameter int COORD_BITS    = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [vfc_pkg::REG_W-1:0] cfg_data,
    vfc_pose_if.sink                      poses,
    vfc_corner_if.source                  corners
);
    import vfc_pkg::*;

    logic [REG_W-1:0] body_length_reg;
    logic [REG_W-1:0] body_width_reg;
    logic [REG_W-1:0] rear_overhang_reg;

    cell_ctrl_t                   ctrl_w [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0]   x_w    [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0]   y_w    [CORDIC_STAGES+1];
    logic signed [ANGLE_W-1:0]    z_w    [CORDIC_STAGES+1];
    logic signed [COORD_BITS-1:0] px_w   [CORDIC_STAGES+1];
    logic signed [COORD_BITS-1:0] py_w   [CORDIC_STAGES+1];

    logic [HEADING_W-1:0] quad_sum;
    logic [HEADING_W-1:0] residue;
    quad_t                quad;
    logic                 take;
    logic                 adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_length_reg   <= BODY_LENGTH_RST;
            body_width_reg    <= BODY_WIDTH_RST;
            rear_overhang_reg <= REAR_OVERHANG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BODY_LENGTH:   body_length_reg   <= cfg_data;
                REG_BODY_WIDTH:    body_width_reg    <= cfg_data;
                REG_REAR_OVERHANG: rear_overhang_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // quadrant reduction: residue lands in [-1/8, 1/8) turn
    always_comb
    begin
        quad_sum = poses.heading + 16'h2000;
        quad     = quad_t'(quad_sum[HEADING_W-1:HEADING_W-2]);
        residue  = poses.heading - {quad, {(HEADING_W-2){1'b0}}};
    end

    assign adv         = !ctrl_w[CORDIC_STAGES].valid || take;
    assign poses.ready = adv;

    assign ctrl_w[0] = '{valid: poses.valid, quad: quad};
    assign x_w[0]    = INV_GAIN;
    assign y_w[0]    = '0;
    assign z_w[0]    = {residue, 8'h00};
    assign px_w[0]   = poses.pose_x;
    assign py_w[0]   = poses.pose_y;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        vfc_cordic_cell #(
            .STAGE      (i),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctrl_in  (ctrl_w[i]),
            .x_in     (x_w[i]),
            .y_in     (y_w[i]),
            .z_in     (z_w[i]),
            .px_in    (px_w[i]),
            .py_in    (py_w[i]),
            .ctrl_out (ctrl_w[i+1]),
            .x_out    (x_w[i+1]),
            .y_out    (y_w[i+1]),
            .z_out    (z_w[i+1]),
            .px_out   (px_w[i+1]),
            .py_out   (py_w[i+1])
        );
    end

    vfc_corner_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_corner (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl_in       (ctrl_w[CORDIC_STAGES]),
        .x_in          (x_w[CORDIC_STAGES]),
        .y_in          (y_w[CORDIC_STAGES]),
        .px_in         (px_w[CORDIC_STAGES]),
        .py_in         (py_w[CORDIC_STAGES]),
        .body_length   (body_length_reg),
        .body_width    (body_width_reg),
        .rear_overhang (rear_overhang_reg),
        .take          (take),
        .corners       (corners)
    );

endmodule
`default_nettype wire

// File: rtl/core/vfc_checker.sv
// Port-level checker for the footprint corner block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vfc_checker #(
    parameter int COORD_BITS = 24
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire logic [1:0]              corner_index,
    input wire logic [COORD_BITS-1:0]   corner_x,
    input wire logic [COORD_BITS-1:0]   corner_y,
    input wire                          last_corner
);
    import vfc_pkg::*;

    logic [7:0] pending_reg, pending_next;
    corner_t    expect_reg;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !(out_fire && last_corner))
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (!in_fire && out_fire && last_corner)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            expect_reg  <= CORNER_FL;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_fire)
            begin
                expect_reg <= corner_t'(expect_reg + 2'd1);
            end
        end
    end

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("corner valid during reset");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (corner_index == expect_reg))
        else $error("corner transactions out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_corner == (corner_index == CORNER_RL)))
        else $error("last_corner does not match the fourth corner");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 8'd0))
        else $error("corner transaction without an outstanding pose");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(corner_x) && $stable(corner_y) && $stable(corner_index)))
        else $error("stalled corner transaction changed");

endmodule

bind vehicle_footprint_corners_top vfc_checker #(
    .COORD_BITS (COORD_BITS)
) u_vfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (poses.valid),
    .in_ready     (poses.ready),
    .out_valid    (corners.valid),
    .out_ready    (corners.ready),
    .corner_index (corners.corner_index),
    .corner_x     (corners.corner_x),
    .corner_y     (corners.corner_y),
    .last_corner  (corners.last_corner)
);
`default_nettype wire
